// ----- hw/rtl/tddb_pkg.sv -----
// package: shared types, codes and the segment table for the display driver
`default_nettype none
package tddb_pkg;

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_ENTRY     = 2'd1;
  localparam logic [1:0] OP_ENTRY_THR = 2'd2;

  localparam logic REG_BLINK_PERIOD = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  localparam logic [15:0] BLINK_PERIOD_RESET = 16'd300;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd60000;
  localparam logic [6:0]  THRESHOLD_RESET    = 7'd50;
  localparam logic [6:0]  NUMBER_MAX         = 7'd99;
  localparam logic [3:0]  BLANK_CODE         = 4'd10;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] ADDR_BASE = 8'hC0;
  localparam logic [7:0] ADDR_STEP = 8'h02;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] number;
    logic [6:0] threshold_update;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] tens_seg;
    logic [7:0] ones_seg;
  } frame_t;

  typedef enum logic [2:0] {
    POS_CMD   = 3'd0,
    POS_ADDR0 = 3'd1,
    POS_SEG0  = 3'd2,
    POS_ADDR1 = 3'd3,
    POS_SEG1  = 3'd4
  } byte_pos_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'b11011110;
      4'd1: code = 8'b10001000;
      4'd2: code = 8'b01011101;
      4'd3: code = 8'b10011101;
      4'd4: code = 8'b10001011;
      4'd5: code = 8'b10010111;
      4'd6: code = 8'b11010111;
      4'd7: code = 8'b10001100;
      4'd8: code = 8'b11011111;
      4'd9: code = 8'b10011111;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tddb_core.sv -----
// core: display state update per item and frame hold register
`default_nettype none
module tddb_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire tddb_pkg::in_item_t item,
  output logic                  frame_valid,
  input  wire logic             frame_take,
  output tddb_pkg::frame_t      frame
);
  import tddb_pkg::*;

  logic [15:0] blink_period;
  logic [15:0] idle_timeout;
  logic [6:0]  threshold_value, threshold_value_next;
  logic [3:0]  tens_digit, tens_digit_next;
  logic [3:0]  ones_digit, ones_digit_next;
  logic        blinking, blinking_next;
  logic        blink_phase, blink_phase_next;
  logic [15:0] blink_count, blink_count_next;
  logic [15:0] idle_count, idle_count_next;
  logic        hold_valid;
  frame_t      frame_q, frame_next;
  logic        emit;
  logic        accept;
  logic [16:0] blink_inc;
  logic [14:0] div_prod;
  logic [3:0]  split_tens;
  logic [6:0]  tens_x10;
  logic [3:0]  split_ones;

  // tens by reciprocal multiply, exact for 0..127
  assign div_prod   = 15'(item.number) * 15'd205;
  assign split_tens = div_prod[14:11];
  assign tens_x10   = {split_tens, 3'b000} - {2'b00, split_tens, 1'b0} + {1'b0, split_tens, 2'b00};
  assign split_ones = 4'(item.number - tens_x10);
  assign blink_inc  = {1'b0, blink_count} + 17'd1;

  assign item_ready  = !hold_valid || frame_take;
  assign accept      = item_valid && item_ready;
  assign frame_valid = hold_valid;
  assign frame       = frame_q;

  always_comb begin
    threshold_value_next = threshold_value;
    tens_digit_next      = tens_digit;
    ones_digit_next      = ones_digit;
    blinking_next        = blinking;
    blink_phase_next     = blink_phase;
    blink_count_next     = blink_count;
    idle_count_next      = idle_count;
    emit                 = 1'b0;
    frame_next           = '{tens_seg: 8'h00, ones_seg: 8'h00};
    case (item.operation)
      OP_TICK: begin
        if (idle_count >= idle_timeout) begin
          tens_digit_next  = BLANK_CODE;
          ones_digit_next  = BLANK_CODE;
          blinking_next    = 1'b0;
          blink_phase_next = 1'b0;
          blink_count_next = 16'd0;
          idle_count_next  = 16'd0;
          emit             = 1'b1;
        end else begin
          idle_count_next = idle_count + 16'd1;
          if (blinking) begin
            if (blink_inc >= {1'b0, blink_period}) begin
              blink_count_next = 16'd0;
              blink_phase_next = !blink_phase;
              emit             = 1'b1;
              if (blink_phase) begin
                frame_next = '{tens_seg: seg_code(tens_digit), ones_seg: seg_code(ones_digit)};
              end
            end else begin
              blink_count_next = blink_inc[15:0];
            end
          end
        end
      end
      OP_ENTRY, OP_ENTRY_THR: begin
        idle_count_next = 16'd0;
        if (item.operation == OP_ENTRY_THR) begin
          threshold_value_next = item.threshold_update;
        end
        if (item.number <= NUMBER_MAX) begin
          tens_digit_next  = split_tens;
          ones_digit_next  = split_ones;
          blinking_next    = item.number > threshold_value_next;
          blink_phase_next = 1'b0;
          blink_count_next = 16'd0;
          emit             = 1'b1;
          frame_next       = '{tens_seg: seg_code(split_tens), ones_seg: seg_code(split_ones)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period    <= BLINK_PERIOD_RESET;
      idle_timeout    <= IDLE_TIMEOUT_RESET;
      threshold_value <= THRESHOLD_RESET;
      tens_digit      <= BLANK_CODE;
      ones_digit      <= BLANK_CODE;
      blinking        <= 1'b0;
      blink_phase     <= 1'b0;
      blink_count     <= 16'd0;
      idle_count      <= 16'd0;
      hold_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLINK_PERIOD: blink_period <= cfg_data;
          REG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        threshold_value <= threshold_value_next;
        tens_digit      <= tens_digit_next;
        ones_digit      <= ones_digit_next;
        blinking        <= blinking_next;
        blink_phase     <= blink_phase_next;
        blink_count     <= blink_count_next;
        idle_count      <= idle_count_next;
      end
      if (accept && emit) begin
        hold_valid <= 1'b1;
      end else if (frame_take) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frame_q <= frame_next;
    end
  end

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> hold_valid)
    else $error("input stalled with no frame held");

  a_phase_only_blinking: assert property (@(posedge clk) disable iff (rst)
    blink_phase |-> blinking)
    else $error("blank phase while not blinking");

  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.operation == OP_TICK && idle_count >= idle_timeout)
      |=> (idle_count == 16'd0 && hold_valid && !blinking))
    else $error("idle timeout did not blank");

endmodule
`default_nettype wire

// ----- hw/rtl/tddb_serializer.sv -----
// serializer: sends one held frame as five bus bytes
`default_nettype none
module tddb_serializer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              frame_valid,
  output logic                   frame_take,
  input  wire tddb_pkg::frame_t  frame,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output tddb_pkg::out_item_t    result
);
  import tddb_pkg::*;

  byte_pos_t pos, pos_next;
  logic      active, active_next;
  frame_t    cur;
  logic      done;

  assign done         = active && result_ready && pos == POS_SEG1;
  assign frame_take   = frame_valid && (!active || done);
  assign result_valid = active;

  always_comb begin
    pos_next    = pos;
    active_next = active;
    if (frame_take) begin
      pos_next    = POS_CMD;
      active_next = 1'b1;
    end else if (done) begin
      active_next = 1'b0;
    end else if (active && result_ready) begin
      case (pos)
        POS_CMD:   pos_next = POS_ADDR0;
        POS_ADDR0: pos_next = POS_SEG0;
        POS_SEG0:  pos_next = POS_ADDR1;
        POS_ADDR1: pos_next = POS_SEG1;
        default:   pos_next = POS_CMD;
      endcase
    end
  end

  always_comb begin
    case (pos)
      POS_CMD:   result = '{bus_byte: CMD_DATA, frame_end: 1'b1, last: 1'b0};
      POS_ADDR0: result = '{bus_byte: ADDR_BASE, frame_end: 1'b0, last: 1'b0};
      POS_SEG0:  result = '{bus_byte: cur.tens_seg, frame_end: 1'b1, last: 1'b0};
      POS_ADDR1: result = '{bus_byte: ADDR_BASE | ADDR_STEP, frame_end: 1'b0, last: 1'b0};
      POS_SEG1:  result = '{bus_byte: cur.ones_seg, frame_end: 1'b1, last: 1'b1};
      default:   result = '{bus_byte: 8'h00, frame_end: 1'b0, last: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= POS_CMD;
      active <= 1'b0;
    end else begin
      pos    <= pos_next;
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      cur <= frame;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (pos == POS_CMD || pos == POS_ADDR0 || pos == POS_SEG0 ||
                pos == POS_ADDR1 || pos == POS_SEG1))
    else $error("byte position out of range");

  a_new_frame_starts: assert property (@(posedge clk) disable iff (rst)
    frame_take |=> (active && pos == POS_CMD))
    else $error("taken frame did not start at command byte");

  a_take_only_free: assert property (@(posedge clk) disable iff (rst)
    (frame_take && active) |-> (pos == POS_SEG1 && result_ready))
    else $error("frame taken while one is still being sent");

endmodule
`default_nettype wire

// ----- hw/rtl/two_digit_display_blink_driver.sv -----
// top level: two digit display driver with threshold blinking and idle blanking
// first bus byte: a frame passes the frame hold register, then the serializer takes it once free and registers it
// throughput: one item per cycle when no frame results and the hold register is empty or being taken;
//   a frame takes five output transfers, and one further frame can wait in the hold register
// reset: synchronous; registers, threshold, digits (blank) and timers reload
`default_nettype none
module two_digit_display_blink_driver (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire tddb_pkg::in_item_t   item,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output tddb_pkg::out_item_t       result
);
  import tddb_pkg::*;

  logic   frame_valid;
  logic   frame_take;
  frame_t frame;

  tddb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .frame_valid (frame_valid),
    .frame_take  (frame_take),
    .frame       (frame)
  );

  tddb_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_take   (frame_take),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
